// ===== rtl/gwlc_pkg.sv =====
// Shared types and constants for the grayscale window/level colormap core.
// Used by gwlc_div and by the top level; depends on nothing else.
`default_nettype none

package gwlc_pkg;

  // Field widths
  localparam int PIX_W      = 32;
  localparam int WIN_W      = 31;
  localparam int LEVEL_W    = 8;
  localparam int RGB_W      = 3 * LEVEL_W;
  localparam int START_W    = PIX_W + 1;
  localparam int DIFF_W     = PIX_W + 2;
  localparam int QUOT_BITS  = LEVEL_W;
  localparam int NUMER_W    = WIN_W + QUOT_BITS;
  localparam int IDX_W      = 8;
  localparam int TABLE_ENTRIES = 256;

  // Port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = PIX_W + IDX_W + RGB_W;
  localparam int OUT_DATA_W = 4 * LEVEL_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN    = 8'h00;
  localparam logic [LEVEL_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR   = 3'd4;

  // Request kinds on the input channel
  localparam logic OP_PIXEL    = 1'b0;
  localparam logic OP_TABLE_WR = 1'b1;

  // Reset values of the window registers
  localparam logic [PIX_W-1:0] CENTER_RESET = 32'sd0;
  localparam logic [WIN_W-1:0] WIDTH_RESET  = 31'd256;

  // Operands handed to the pipelined divider
  typedef struct packed {
    logic [NUMER_W-1:0] numer;
    logic [WIN_W-1:0]   denom;
  } div_req_t;

  // Per-request side information that travels beside the divider
  typedef struct packed {
    logic              is_wr;
    logic [IDX_W-1:0]  idx;
    logic [RGB_W-1:0]  rgb;
    logic              zero;
    logic              hi;
    logic              lo;
  } tag_t;

endpackage : gwlc_pkg

`default_nettype wire

// ===== rtl/gwlc_div.sv =====
// Pipelined restoring divider giving an 8-bit quotient, one bit per stage.
// Depends on gwlc_pkg; the numerator must be below 256 times the divisor.
`default_nettype none

module gwlc_div (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire gwlc_pkg::div_req_t                req,
  output logic [gwlc_pkg::QUOT_BITS-1:0]         quot
);
  import gwlc_pkg::*;

  // Per-stage partial remainder, pending numerator bits, quotient and divisor
  logic [WIN_W-1:0]     rem_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] low_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] quo_r [QUOT_BITS];
  logic [WIN_W-1:0]     den_r [QUOT_BITS];

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_stage
    logic [WIN_W-1:0]     rem_in;
    logic [QUOT_BITS-1:0] low_in;
    logic [QUOT_BITS-1:0] quo_in;
    logic [WIN_W-1:0]     den_in;
    logic [WIN_W:0]       trial;
    logic                 ge;

    // The top bits of the numerator are already below the divisor.
    if (i == 0) begin : g_first
      assign rem_in = req.numer[NUMER_W-1 -: WIN_W];
      assign low_in = req.numer[QUOT_BITS-1:0];
      assign quo_in = '0;
      assign den_in = req.denom;
    end else begin : g_rest
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
    end

    // Bring down one numerator bit and try a subtraction.
    assign trial = {rem_in, low_in[QUOT_BITS-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? WIN_W'(trial - {1'b0, den_in}) : trial[WIN_W-1:0];
        low_r[i] <= {low_in[QUOT_BITS-2:0], 1'b0};
        quo_r[i] <= {quo_in[QUOT_BITS-2:0], ge};
        den_r[i] <= den_in;
      end
    end
  end

  assign quot = quo_r[QUOT_BITS-1];

endmodule : gwlc_div

`default_nettype wire

// ===== rtl/grayscale_window_level_colormap_core.sv =====
// Top level of the grayscale window/level core with a 256-entry color table.
// Depends on gwlc_pkg and gwlc_div.
//
//   Channel  Direction  Handshake              Payload
//   in_      slave      in_tvalid / in_tready  tdata: pixel, index, r, g, b; tuser: opcode
//   out_     master     out_tvalid/out_tready  tdata: red, green, blue, alpha
//   cfg_     slave      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request enters per clock while out_tready does not stall the pipeline. A pixel
// request passes through window start, difference, scaling, eight divider stages (one
// quotient bit each), table read and output register before out_tvalid. Table writes
// take effect at the table read stage in request order and produce no result. A stall
// on out_tready freezes the whole pipeline, and in_tready falls with it. rst_n clears
// all valid bits and restores the window registers; the table is undefined until written.
`default_nettype none

module grayscale_window_level_colormap_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [31:0] pixel_value, [39:32] table_index, [47:40] table_red,
  // [55:48] table_green, [63:56] table_blue
  input  wire logic [gwlc_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] opcode
  input  wire logic                                 in_tuser,
  // Output stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic [gwlc_pkg::OUT_DATA_W-1:0]           out_tdata,
  // Configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [gwlc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [gwlc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gwlc_pkg::*;

  // Configuration registers
  logic [PIX_W-1:0] center_r;
  logic [WIN_W-1:0] width_r;
  logic             reverse_r;
  logic             mono1_r;
  logic             color_r;

  // Pipeline control
  logic en;
  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Stage 1: window start
  logic               s1_valid_r;
  tag_t               s1_tag_r;
  logic [PIX_W-1:0]   s1_pixel_r;
  logic [START_W-1:0] s1_start_r;
  logic [START_W-1:0] start_c;
  tag_t               in_tag_c;

  // Stage 2: offset into the window and range flags
  logic              s2_valid_r;
  tag_t              s2_tag_r;
  logic [WIN_W-1:0]  s2_diff_r;
  logic [DIFF_W-1:0] diff_c;
  logic              hi_c;
  logic              lo_c;
  tag_t              s2_tag_c;

  // Stage 3: scaled numerator
  logic               s3_valid_r;
  tag_t               s3_tag_r;
  logic [NUMER_W-1:0] s3_numer_r;
  logic [NUMER_W-1:0] numer_c;

  // Divider and side pipeline
  div_req_t             div_req;
  logic [QUOT_BITS-1:0] quot;
  logic [QUOT_BITS-1:0] dv_r;
  tag_t                 dtag_r [QUOT_BITS];
  tag_t                 dtag;

  // Level stage and color table
  logic [LEVEL_W-1:0] base_c;
  logic [LEVEL_W-1:0] level_c;
  logic               invert_c;
  logic               lv_valid_r;
  logic               lv_write_r;
  logic [LEVEL_W-1:0] lv_level_r;
  logic [RGB_W-1:0]   table_mem [TABLE_ENTRIES];
  logic [RGB_W-1:0]   rd_r;
  logic [RGB_W-1:0]   out_rgb_c;

  // The whole pipeline moves whenever the output register can take a result.
  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration register decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= CENTER_RESET;
      width_r   <= WIDTH_RESET;
      reverse_r <= 1'b0;
      mono1_r   <= 1'b0;
      color_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTER:  center_r  <= cfg_data;
        CFG_WIDTH:   width_r   <= cfg_data[WIN_W-1:0];
        CFG_REVERSE: reverse_r <= cfg_data[0];
        CFG_MONO1:   mono1_r   <= cfg_data[0];
        CFG_COLOR:   color_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: start = center - floor(width / 2).
  assign start_c = START_W'($signed({center_r[PIX_W-1], center_r})
                            - $signed({2'b00, width_r[WIN_W-1:1]}));

  always_comb begin
    in_tag_c       = '0;
    in_tag_c.is_wr = (in_tuser == OP_TABLE_WR);
    in_tag_c.idx   = in_tdata[PIX_W +: IDX_W];
    in_tag_c.rgb   = {in_tdata[PIX_W+IDX_W +: LEVEL_W],
                      in_tdata[PIX_W+IDX_W+LEVEL_W +: LEVEL_W],
                      in_tdata[PIX_W+IDX_W+2*LEVEL_W +: LEVEL_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r   <= in_tag_c;
      s1_pixel_r <= in_tdata[PIX_W-1:0];
      s1_start_r <= start_c;
    end
  end

  // Stage 2: offset from the start and where it falls against the window.
  assign diff_c = DIFF_W'($signed({{2{s1_pixel_r[PIX_W-1]}}, s1_pixel_r})
                          - $signed({s1_start_r[START_W-1], s1_start_r}));
  assign hi_c   = ($signed(diff_c) >= $signed({3'b000, width_r}));
  assign lo_c   = diff_c[DIFF_W-1] || (diff_c == '0);

  always_comb begin
    s2_tag_c      = s1_tag_r;
    s2_tag_c.zero = (width_r == '0);
    s2_tag_c.hi   = hi_c;
    s2_tag_c.lo   = lo_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag_r  <= s2_tag_c;
      s2_diff_r <= diff_c[WIN_W-1:0];
    end
  end

  // Stage 3: numerator 255 * offset as a shift and a subtract.
  assign numer_c = {s2_diff_r, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, s2_diff_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag_r   <= s2_tag_r;
      s3_numer_r <= numer_c;
    end
  end

  // Divider stages, with the request's side information kept in step.
  assign div_req.numer = s3_numer_r;
  assign div_req.denom = width_r;

  gwlc_div u_div (
    .clk  (clk),
    .en   (en),
    .req  (div_req),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[QUOT_BITS-2:0], s3_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dtag_r[0] <= s3_tag_r;
      for (int i = 1; i < QUOT_BITS; i++) begin
        dtag_r[i] <= dtag_r[i-1];
      end
    end
  end

  assign dtag = dtag_r[QUOT_BITS-1];

  // Saturate, then invert unless the window is blank; a blank window gives level zero.
  always_comb begin
    if (dtag.hi) begin
      base_c = LEVEL_MAX;
    end else if (dtag.lo) begin
      base_c = LEVEL_MIN;
    end else begin
      base_c = quot;
    end
    invert_c = (reverse_r ^ mono1_r) && !dtag.zero;
    if (dtag.zero) begin
      level_c = LEVEL_MIN;
    end else if (invert_c) begin
      level_c = LEVEL_MAX - base_c;
    end else begin
      level_c = base_c;
    end
  end

  // Color table: writes and reads share this stage, so order is kept.
  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_r[QUOT_BITS-1] && dtag.is_wr) begin
        table_mem[dtag.idx] <= dtag.rgb;
      end
      rd_r <= table_mem[level_c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_valid_r <= 1'b0;
    end else if (en) begin
      lv_valid_r <= dv_r[QUOT_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv_write_r <= dtag.is_wr;
      lv_level_r <= level_c;
    end
  end

  // Output register: grey or table color, opaque alpha.
  assign out_rgb_c = color_r ? rd_r : {lv_level_r, lv_level_r, lv_level_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= lv_valid_r && !lv_write_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {ALPHA_OPAQUE, out_rgb_c[LEVEL_W-1:0],
                     out_rgb_c[LEVEL_W +: LEVEL_W], out_rgb_c[2*LEVEL_W +: LEVEL_W]};
    end
  end

  // A table write leaving the table stage never turns into a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    en && lv_valid_r && lv_write_r |=> !out_valid_r)
    else $error("table write produced a result");

  // A pixel leaving the table stage always turns into a result.
  a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
    en && lv_valid_r && !lv_write_r |=> out_valid_r)
    else $error("pixel request was lost");

  // With a nonzero width an offset cannot be both past the end and before the start.
  a_range_flags: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_tag_r.zero |-> !(s2_tag_r.hi && s2_tag_r.lo))
    else $error("window range flags conflict");

  // Reset empties the output register, the table stage and the divider valid bits.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !lv_valid_r && (dv_r == '0))
    else $error("reset left a request in flight");

endmodule : grayscale_window_level_colormap_core

`default_nettype wire
